### hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation and status codes, and the control word that the top level
// broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam int ValueW = 32;
	localparam int PrioW  = 16;
	localparam int OccW   = 7;

	// shift_in: an insert that takes effect; shift_out: a remove that takes effect
	typedef struct packed {
		logic shift_in;
		logic shift_out;
	} cell_ctrl_t;

endpackage

### hw/rtl/spq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface spq_in_if
	import spq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic signed [ValueW-1:0] item_value;
	logic signed [PrioW-1:0]  item_priority;

	modport source (output valid, output op, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input op, input item_value, input item_priority,
		output ready);
endinterface

### hw/rtl/spq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface spq_out_if
	import spq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [ValueW-1:0] removed_value;
	logic signed [PrioW-1:0]  removed_priority;
	logic        [OccW-1:0]   occupancy;

	modport source (output valid, output status, output removed_value,
		output removed_priority, output occupancy, input ready);
	modport sink (input valid, input status, input removed_value,
		input removed_priority, input occupancy, output ready);
endinterface

### hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Up to DEPTH value/priority entries kept in priority order in a chain of
// cells, smallest priority number at the head.
// ----------------------------------------------------------------------------
// Every request word gives one response word. An insert lands ahead of all
// stored entries of greater or equal priority, so among equal priorities the
// newest is served first; an insert into a full queue reports overflow and
// changes nothing. A remove returns the head entry, or reports underflow on an
// empty queue with zero value and priority. The occupancy field carries the
// entry count after the operation, its low seven bits when DEPTH exceeds 127.
// The queue takes one word per cycle unless a result waits untaken: every
// cell compares its priority with the incoming one in parallel and the whole
// chain shifts at once, so the result is registered as the word is accepted.
// The response register lets a new request in while the previous result
// waits, as long as it is being taken in the same cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_in_if.sink     req,
	spq_out_if.source  rsp
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_next;
	logic            take;
	logic            full;
	logic            empty;
	cell_ctrl_t      ctrl;

	logic                     ge_w    [DEPTH];
	logic signed [ValueW-1:0] value_w [DEPTH];
	logic signed [PrioW-1:0]  prio_w  [DEPTH];

	logic                     rsp_valid_q;
	status_t                  status_q;
	logic signed [ValueW-1:0] rem_value_q;
	logic signed [PrioW-1:0]  rem_prio_q;
	logic [OccW-1:0]          occ_q;
	logic [CntW+OccW-1:0]     occ_wide;

	// Accept while the response slot is free or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);

	// Broadcast to the chain; drop operations that would overflow or underflow.
	always_comb begin
		ctrl.shift_in  = take && (req.op == OP_INSERT) && !full;
		ctrl.shift_out = take && (req.op == OP_REMOVE) && !empty;
		count_next = count_q;
		if (ctrl.shift_in) begin
			count_next = count_q + CntW'(1);
		end else if (ctrl.shift_out) begin
			count_next = count_q - CntW'(1);
		end
	end

	// Low bits of the count after the operation.
	assign occ_wide = {{OccW{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Chain of cells: the head has no left neighbor, the tail no right one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     left_ge;
		logic signed [ValueW-1:0] left_value;
		logic signed [PrioW-1:0]  left_prio;
		logic signed [ValueW-1:0] right_value;
		logic signed [PrioW-1:0]  right_prio;
		logic                     occ;

		assign occ = (CntW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_ge    = 1'b0;
			assign left_value = req.item_value;
			assign left_prio  = req.item_priority;
		end else begin : g_body
			assign left_ge    = ge_w[i-1];
			assign left_value = value_w[i-1];
			assign left_prio  = prio_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_value = value_w[i];
			assign right_prio  = prio_w[i];
		end else begin : g_inner
			assign right_value = value_w[i+1];
			assign right_prio  = prio_w[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ),
			.new_value   (req.item_value),
			.new_prio    (req.item_priority),
			.left_ge     (left_ge),
			.left_value  (left_value),
			.left_prio   (left_prio),
			.right_value (right_value),
			.right_prio  (right_prio),
			.ge          (ge_w[i]),
			.value       (value_w[i]),
			.prio        (prio_w[i])
		);
	end

	// Response register: hold until taken, load on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			occ_q       <= occ_wide[OccW-1:0];
			rem_value_q <= '0;
			rem_prio_q  <= '0;
			if (req.op == OP_INSERT) begin
				status_q <= full ? ST_OVERFLOW : ST_DONE;
			end else if (empty) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q    <= ST_DONE;
				rem_value_q <= value_w[0];
				rem_prio_q  <= prio_w[0];
			end
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.removed_value    = rem_value_q;
	assign rsp.removed_priority = rem_prio_q;
	assign rsp.occupancy        = occ_q;

endmodule

### hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds an entry and takes the new entry,
// its left neighbor or its right neighbor as the broadcast control says.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic                     occ,
	input  logic signed [ValueW-1:0] new_value,
	input  logic signed [PrioW-1:0]  new_prio,
	input  logic                     left_ge,
	input  logic signed [ValueW-1:0] left_value,
	input  logic signed [PrioW-1:0]  left_prio,
	input  logic signed [ValueW-1:0] right_value,
	input  logic signed [PrioW-1:0]  right_prio,
	output logic                     ge,
	output logic signed [ValueW-1:0] value,
	output logic signed [PrioW-1:0]  prio
);

	logic signed [ValueW-1:0] value_q;
	logic signed [PrioW-1:0]  prio_q;

	// empty slots count as "at or behind the insert point"
	assign ge    = !occ || (prio_q >= new_prio);
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_in && ge) begin
			if (left_ge) begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end else begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end
		end else if (ctrl.shift_out) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

### verif/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove words into the queue and checks every response
// word against an in-bench model of the sorted entry list. A short table of
// directed words comes first: extremes, ties, underflow, a full queue and
// overflow. Random bursts follow, leaning toward inserts or removes so the
// queue swings between empty and full. Both channels idle at random in two of
// the three phases, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int QDepth       = 64;
	localparam int ClkPeriod    = 10;
	localparam int ResetCycles  = 5;
	localparam int RandomWords  = 485;     // per idle phase, three phases
	localparam int HoldCycles   = 200;     // long response hold-off
	localparam int DrainCycles  = 16;      // settle time after the last response
	localparam int CycleLimit   = 400000;
	localparam int ReportLimit  = 10;

	// One stored entry of the queue model
	typedef struct {
		logic signed [ValueW-1:0] value;
		logic signed [PrioW-1:0]  prio;
	} entry_t;

	// One response word as the block should produce it
	typedef struct {
		status_t                  status;
		logic signed [ValueW-1:0] removed_value;
		logic signed [PrioW-1:0]  removed_priority;
		logic        [OccW-1:0]   occupancy;
	} outcome_t;

	// One row of the directed table: a word sent reps times, with an optional
	// hand-written outcome that replaces the model's for that row
	typedef struct {
		op_t                      op;
		logic        [ValueW-1:0] value;
		logic        [PrioW-1:0]  prio;
		int                       reps;
		bit                       typed;
		outcome_t                 want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	spq_in_if  req ();
	spq_out_if rsp ();

	sorted_priority_queue #(
		.DEPTH(QDepth)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Model state: entries in service order, head at index 0
	entry_t   held_entries[$];
	// Outcomes of accepted request words whose response has not come yet
	outcome_t pending_outcomes[$];

	int mismatches = 0;
	int cycle_count = 0;

	// Idle rates in percent, set per phase by the stimulus
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Long hold-off handshake: stimulus raises the request, receiver counts
	bit hold_request = 1'b0;
	bit hold_taken   = 1'b0;
	int hold_left    = 0;

	localparam outcome_t NoOutcome = '{ST_DONE, '0, '0, '0};

	dir_row_t directed [16] = '{
		// remove on an empty queue straight after reset
		'{OP_REMOVE, 32'h0000_0000, 16'h0000, 1,  1'b1, '{ST_UNDERFLOW, '0, '0, 7'd0}},
		// value and priority extremes
		'{OP_INSERT, 32'h7fff_ffff, 16'h7fff, 1,  1'b1, '{ST_DONE, '0, '0, 7'd1}},
		'{OP_INSERT, 32'h8000_0000, 16'h8000, 1,  1'b1, '{ST_DONE, '0, '0, 7'd2}},
		// two equal priorities: the newer one must come out first
		'{OP_INSERT, 32'h0000_0000, 16'h0000, 1,  1'b0, NoOutcome},
		'{OP_INSERT, 32'hffff_ffff, 16'h0000, 1,  1'b0, NoOutcome},
		'{OP_INSERT, 32'h5555_5555, 16'h5555, 1,  1'b0, NoOutcome},
		'{OP_INSERT, 32'haaaa_aaaa, 16'haaaa, 1,  1'b0, NoOutcome},
		// drain all six; payload fields are ignored on remove
		'{OP_REMOVE, 32'hdead_beef, 16'h1234, 6,  1'b0, NoOutcome},
		'{OP_REMOVE, 32'hffff_ffff, 16'hffff, 1,  1'b1, '{ST_UNDERFLOW, '0, '0, 7'd0}},
		// fill to the brim, the last one lands at the head
		'{OP_INSERT, 32'h0000_1234, 16'hffff, 63, 1'b0, NoOutcome},
		'{OP_INSERT, 32'h0000_abcd, 16'h8000, 1,  1'b0, NoOutcome},
		// insert into a full queue changes nothing
		'{OP_INSERT, 32'h7fff_ffff, 16'h8000, 1,  1'b1, '{ST_OVERFLOW, '0, '0, 7'd64}},
		// a freed slot is usable at once
		'{OP_REMOVE, 32'h0000_0000, 16'h0000, 1,  1'b0, NoOutcome},
		'{OP_INSERT, 32'h0000_0001, 16'h0001, 1,  1'b0, NoOutcome},
		'{OP_REMOVE, 32'h0000_0000, 16'h0000, 64, 1'b0, NoOutcome},
		'{OP_REMOVE, 32'h0000_0000, 16'h0000, 1,  1'b1, '{ST_UNDERFLOW, '0, '0, 7'd0}}
	};

	// Apply one request word to the model and return the response it causes.
	function automatic outcome_t apply_to_queue(op_t op, logic signed [ValueW-1:0] value,
			logic signed [PrioW-1:0] prio);
		outcome_t res;
		entry_t   ent;
		int       pos;
		res = NoOutcome;
		if (op == OP_INSERT) begin
			if (held_entries.size() >= QDepth) begin
				res.status = ST_OVERFLOW;
			end else begin
				// land ahead of every entry with a greater or equal priority
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].prio < prio)
					pos++;
				ent.value = value;
				ent.prio  = prio;
				held_entries.insert(pos, ent);
			end
		end else begin
			if (held_entries.size() == 0) begin
				res.status = ST_UNDERFLOW;
			end else begin
				ent = held_entries.pop_front();
				res.removed_value    = ent.value;
				res.removed_priority = ent.prio;
			end
		end
		res.occupancy = OccW'(held_entries.size());
		return res;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Cycle counter and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one request word, hold it until the handshake, then record the
	// outcome. Call at a rising edge; returns at the edge that accepts it.
	task automatic send_word(op_t op, logic [ValueW-1:0] value, logic [PrioW-1:0] prio,
			bit typed, outcome_t want);
		outcome_t modeled;
		// drop valid for a random number of cycles first
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.op            <= op;
		req.item_value    <= value;
		req.item_priority <= prio;
		// sample the handshake mid-cycle, where both sides have settled
		@(negedge clk);
		while (!req.ready)
			@(negedge clk);
		modeled = apply_to_queue(op, value, prio);
		pending_outcomes.push_back(typed ? want : modeled);
		@(posedge clk);
	endtask

	// Lower valid and wait until every outstanding response has come back.
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Response side: random ready, plus one long hold-off counted here
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				// start the hold-off: the block fills up and stalls its input
				hold_taken = 1'b1;
				hold_left  = HoldCycles;
				rsp.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Check each accepted response word against the oldest outcome. Sample
	// at the falling edge; the word is taken at the next rising edge.
	always @(negedge clk) begin : check_response
		outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("unexpected response: status %0d value %0d prio %0d occ %0d",
						rsp.status, rsp.removed_value, rsp.removed_priority,
						rsp.occupancy);
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp.status !== want.status
						|| rsp.removed_value !== want.removed_value
						|| rsp.removed_priority !== want.removed_priority
						|| rsp.occupancy !== want.occupancy) begin
					mismatches++;
					if (mismatches <= ReportLimit) begin
						$write("mismatch at cycle %0d: expected status %0d value %0d ",
							cycle_count, want.status, want.removed_value);
						$write("prio %0d occ %0d, ",
							want.removed_priority, want.occupancy);
						$display("got status %0d value %0d prio %0d occ %0d",
							rsp.status, rsp.removed_value, rsp.removed_priority,
							rsp.occupancy);
					end
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		op_t               op;
		logic [ValueW-1:0] value;
		logic [PrioW-1:0]  prio;
		int                burst_left;
		int                insert_pct;

		// hold every input at a known value from time zero
		arst_n            <= 1'b0;
		req.valid         <= 1'b0;
		req.op            <= OP_INSERT;
		req.item_value    <= '0;
		req.item_priority <= '0;
		burst_left = 0;
		insert_pct = 50;

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the first idle setting
		send_idle_pct = 19;
		recv_idle_pct = 55;
		for (int i = 0; i < $size(directed); i++) begin
			for (int k = 0; k < directed[i].reps; k++)
				send_word(directed[i].op, directed[i].value, directed[i].prio,
					directed[i].typed, directed[i].want);
		end
		wait_for_drain();

		// random bursts, three idle phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 19;
					// keep offering words while the response side holds off
					hold_request = 1'b1;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RandomWords; n++) begin
				// pick a new burst bias: mostly inserts, even, or mostly removes
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 90);
					case ($urandom_range(0, 2))
						0:       insert_pct = 85;
						1:       insert_pct = 50;
						default: insert_pct = 15;
					endcase
				end
				burst_left--;
				op    = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
				value = $urandom;
				// half full-range priorities, half a narrow band to force ties
				if ($urandom_range(0, 1) == 0)
					prio = PrioW'($urandom);
				else
					prio = PrioW'($urandom_range(0, 7)) - PrioW'(4);
				send_word(op, value, prio, 1'b0, NoOutcome);
			end
			// pause the sender until the queue has answered everything
			wait_for_drain();
		end

		// let any stray response word show up before the verdict
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_in_if.sv
hw/rtl/spq_out_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
